@@ src/twsd_pkg.sv @@
// shared types and constants for the two-wire segment display driver
// no dependencies; imported by twsd_seq and two_wire_segment_display_driver
package twsd_pkg;

    // pin sequencer steps
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_BIT_LOW  = 4'd3,
        PH_BIT_HIGH = 4'd4,
        PH_ACK_REL  = 4'd5,
        PH_ACK_CLK  = 4'd6,
        PH_STOP_A   = 4'd7,
        PH_STOP_B   = 4'd8,
        PH_STOP_C   = 4'd9
    } twsd_phase_t;

    // command codes
    localparam logic [1:0] CMD_SHOW   = 2'd1;
    localparam logic [1:0] CMD_BRIGHT = 2'd2;

    // frame codes
    localparam logic [1:0] FRAME_DATA = 2'd0;
    localparam logic [1:0] FRAME_ADDR = 2'd1;
    localparam logic [1:0] FRAME_CTRL = 2'd2;

    // controller command bytes
    localparam logic [7:0] DATA_CMD    = 8'h40;
    localparam logic [7:0] ADDR_CMD    = 8'hC0;
    localparam logic [7:0] CTRL_CMD    = 8'h80;
    localparam logic [7:0] CTRL_ON_BIT = 8'h08;

    // last byte index of the address frame (address, left, right)
    localparam logic [1:0] ADDR_LAST_BYTE = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] left_segments;
        logic [7:0] right_segments;
        logic [2:0] duty_level;
        logic       display_enable;
        logic       dio_sense;
    } twsd_item_t;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic ack_valid;
        logic ack_value;
        logic rejected;
    } twsd_res_t;

endpackage

@@ src/two_wire_segment_display_driver.sv @@
// top level of the two-wire segment display driver: input register, sequencer, result register
// depends on twsd_pkg and twsd_seq
//
//  channel | signals                         | carries
//  --------+---------------------------------+------------------------------------------
//  item    | item_valid / item_ready         | cmd, segments, duty, enable, dio_sense
//  result  | result_valid / result_ready     | clk_level, dio_level, busy_res, ack, rejected
//
// one transaction per cycle sustained while result_ready stays high; each item is one delay tick of the pin sequence
// an item is held in the input register and its result is then held in the result register
// the sequencer state only advances when an item moves from the input register into
// the result register, so stalls on the result side freeze the pin sequence
// reset empties both registers and leaves the sequencer idle
module two_wire_segment_display_driver #(
    parameter int TICKS_PER_STEP = 1
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [1:0] cmd,
    input  logic [7:0] left_segments,
    input  logic [7:0] right_segments,
    input  logic [2:0] duty_level,
    input  logic       display_enable,
    input  logic       dio_sense,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       clk_level,
    output logic       dio_level,
    output logic       busy_res,
    output logic       ack_valid,
    output logic       ack_value,
    output logic       rejected
);
    import twsd_pkg::*;

    // input stage
    logic       item_valid_reg;
    twsd_item_t item_reg;

    // result stage
    logic       res_valid_reg;
    twsd_res_t  res_reg;
    twsd_res_t  res_next;

    // stage moves when the result register is free or being emptied
    logic       step_en;
    logic       out_free;

    assign out_free   = !res_valid_reg || result_ready;
    assign step_en    = item_valid_reg && out_free;
    assign item_ready = !item_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    // payload captured without reset
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= '{cmd:            cmd,
                          left_segments:  left_segments,
                          right_segments: right_segments,
                          duty_level:     duty_level,
                          display_enable: display_enable,
                          dio_sense:      dio_sense};
        end
    end

    // the sequencer computes the tick's pin levels and flags
    twsd_seq #(
        .TICKS_PER_STEP (TICKS_PER_STEP)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (item_reg),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign clk_level    = res_reg.clk_level;
    assign dio_level    = res_reg.dio_level;
    assign busy_res     = res_reg.busy_res;
    assign ack_valid    = res_reg.ack_valid;
    assign ack_value    = res_reg.ack_value;
    assign rejected     = res_reg.rejected;

    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !out_free |=> item_valid_reg)
        else $error("buffered transaction dropped under stall");

    a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> res_valid_reg)
        else $error("sequencer step produced no result");

    a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result_ready |=> $stable(res_reg))
        else $error("result changed while stalled");

endmodule

@@ src/twsd_seq.sv @@
// pin sequencer: holds the frame/byte/bit/step state and computes one result per tick
// depends on twsd_pkg
module twsd_seq #(
    parameter int TICKS_PER_STEP = 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  twsd_pkg::twsd_item_t item,
    output twsd_pkg::twsd_res_t  res
);
    import twsd_pkg::*;

    localparam int TICK_W = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;
    localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICKS_PER_STEP - 1);

    logic              busy_reg,  busy_next;
    logic [1:0]        frame_reg, frame_next;
    logic [1:0]        byte_reg,  byte_next;
    logic [2:0]        bit_reg,   bit_next;
    twsd_phase_t       phase_reg, phase_next;
    logic [7:0]        shift_reg, shift_next;
    logic [TICK_W-1:0] tick_reg,  tick_next;
    logic [7:0]        pend_reg  [2];
    logic [7:0]        pend_next [2];
    logic              bitv;
    logic              last;
    logic              active;

    always_comb
    begin
        busy_next    = busy_reg;
        frame_next   = frame_reg;
        byte_next    = byte_reg;
        bit_next     = bit_reg;
        phase_next   = phase_reg;
        shift_next   = shift_reg;
        tick_next    = tick_reg;
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        res          = '0;
        bitv         = 1'b0;
        last         = 1'b0;
        active       = 1'b0;

        // command intake
        if (item.cmd == CMD_SHOW || item.cmd == CMD_BRIGHT)
        begin
            if (busy_reg)
            begin
                res.rejected = 1'b1;
            end
            else
            begin
                busy_next  = 1'b1;
                phase_next = PH_START_A;
                tick_next  = '0;
                byte_next  = '0;
                bit_next   = '0;
                if (item.cmd == CMD_SHOW)
                begin
                    frame_next   = FRAME_DATA;
                    shift_next   = DATA_CMD;
                    pend_next[0] = item.left_segments;
                    pend_next[1] = item.right_segments;
                end
                else
                begin
                    frame_next = FRAME_CTRL;
                    shift_next = CTRL_CMD | {5'd0, item.duty_level}
                               | (item.display_enable ? CTRL_ON_BIT : 8'd0);
                end
            end
        end

        active = busy_next && (phase_next >= PH_START_A) && (phase_next <= PH_STOP_C);

        if (active)
        begin
            bitv = shift_next[bit_next];
            unique case (phase_next)
                PH_START_A:  begin res.clk_level = 1'b1; res.dio_level = 1'b1; end
                PH_START_B:  begin res.clk_level = 1'b1; res.dio_level = 1'b0; end
                PH_BIT_LOW:  begin res.clk_level = 1'b0; res.dio_level = bitv; end
                PH_BIT_HIGH: begin res.clk_level = 1'b1; res.dio_level = bitv; end
                PH_ACK_REL:  begin res.clk_level = 1'b0; res.dio_level = 1'b1; end
                PH_ACK_CLK:  begin res.clk_level = 1'b1; res.dio_level = 1'b1; end
                PH_STOP_A:   begin res.clk_level = 1'b0; res.dio_level = 1'b0; end
                PH_STOP_B:   begin res.clk_level = 1'b1; res.dio_level = 1'b0; end
                default:     begin res.clk_level = 1'b1; res.dio_level = 1'b1; end
            endcase
            res.busy_res = 1'b1;
            last = (tick_next >= TICK_LAST);
            if (phase_next == PH_ACK_CLK && last)
            begin
                res.ack_valid = 1'b1;
                res.ack_value = item.dio_sense;
            end
            if (last)
            begin
                tick_next = '0;
                unique case (phase_next)
                    PH_START_A:  phase_next = PH_START_B;
                    PH_START_B:  phase_next = PH_BIT_LOW;
                    PH_BIT_LOW:  phase_next = PH_BIT_HIGH;
                    PH_BIT_HIGH:
                    begin
                        if (bit_next == 3'd7)
                        begin
                            phase_next = PH_ACK_REL;
                        end
                        else
                        begin
                            bit_next   = bit_next + 3'd1;
                            phase_next = PH_BIT_LOW;
                        end
                    end
                    PH_ACK_REL:  phase_next = PH_ACK_CLK;
                    PH_ACK_CLK:
                    begin
                        if (frame_next == FRAME_ADDR && byte_next < ADDR_LAST_BYTE)
                        begin
                            // next byte comes from the held segment patterns
                            shift_next = pend_next[byte_next[0]];
                            byte_next  = byte_next + 2'd1;
                            bit_next   = '0;
                            phase_next = PH_BIT_LOW;
                        end
                        else
                        begin
                            phase_next = PH_STOP_A;
                        end
                    end
                    PH_STOP_A:   phase_next = PH_STOP_B;
                    PH_STOP_B:   phase_next = PH_STOP_C;
                    PH_STOP_C:
                    begin
                        if (frame_next == FRAME_DATA)
                        begin
                            frame_next = FRAME_ADDR;
                            byte_next  = '0;
                            bit_next   = '0;
                            shift_next = ADDR_CMD;
                            phase_next = PH_START_A;
                        end
                        else
                        begin
                            busy_next  = 1'b0;
                            phase_next = PH_IDLE;
                        end
                    end
                    default:
                    begin
                        busy_next  = 1'b0;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else
            begin
                tick_next = tick_next + 1'b1;
            end
        end
        else
        begin
            // idle: lines released high
            busy_next     = 1'b0;
            phase_next    = PH_IDLE;
            tick_next     = '0;
            res.clk_level = 1'b1;
            res.dio_level = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            frame_reg <= FRAME_DATA;
            byte_reg  <= '0;
            bit_reg   <= '0;
            phase_reg <= PH_IDLE;
            shift_reg <= '0;
            tick_reg  <= '0;
        end
        else if (step_en)
        begin
            busy_reg  <= busy_next;
            frame_reg <= frame_next;
            byte_reg  <= byte_next;
            bit_reg   <= bit_next;
            phase_reg <= phase_next;
            shift_reg <= shift_next;
            tick_reg  <= tick_next;
        end
    end

    // segment bytes held for the address frame
    always_ff @(posedge clk)
    begin
        if (step_en)
        begin
            pend_reg[0] <= pend_next[0];
            pend_reg[1] <= pend_next[1];
        end
    end

    a_ack_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.ack_valid |-> res.busy_res)
        else $error("ack reported outside a sequence");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.rejected |-> busy_reg)
        else $error("command rejected while idle");

    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> phase_reg == PH_IDLE)
        else $error("sequencer not idle while not busy");

    a_after_ack: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res.ack_valid |=> (phase_reg == PH_BIT_LOW || phase_reg == PH_STOP_A))
        else $error("bad step after ack clock");

endmodule
